// ===== design/qenc_pkg.sv =====
// Package for the quadrature encoder event unit.
// Holds item, result and state types, the step lookup table and sizes.
// No dependencies.
package qenc_pkg;

    localparam int COUNT_BITS = 8;
    localparam int NET_W      = 9;
    localparam int DIFF_W     = (COUNT_BITS + 1 > NET_W) ? COUNT_BITS + 1 : NET_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_SEED   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION_FLIP    = 1'd0,
        CFG_BUTTON_ACTIVE_LOW = 1'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_POS  = 2'd1,
        STEP_NEG  = 2'd2
    } step_t;

    localparam logic [1:0] AB_IDLE = 2'd3;

    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_POS,  STEP_NEG,  STEP_NONE,
        STEP_NEG,  STEP_NONE, STEP_NONE, STEP_POS,
        STEP_POS,  STEP_NONE, STEP_NONE, STEP_NEG,
        STEP_NONE, STEP_NEG,  STEP_POS,  STEP_NONE
    };

    typedef struct packed {
        kind_t kind;
        logic  pin_a;
        logic  pin_b;
        logic  pin_button;
    } item_t;

    typedef struct packed {
        logic signed [NET_W-1:0] net_steps;
        logic                    pressed;
    } result_t;

    typedef struct packed {
        logic [1:0]            previous_ab;
        logic [COUNT_BITS-1:0] cw_count;
        logic [COUNT_BITS-1:0] ccw_count;
        logic                  last_button;
        logic                  button_known;
        logic                  press_pending;
    } state_t;

    typedef struct packed {
        logic direction_flip;
        logic button_active_low;
    } cfg_t;

endpackage

// ===== design/qenc_if.sv =====
// Valid/ready channel interfaces for encoder items and results.
// Depends on qenc_pkg.
interface qenc_in_if;
    import qenc_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    logic  pin_a;
    logic  pin_b;
    logic  pin_button;

    modport source (output valid, kind, pin_a, pin_b, pin_button, input ready);
    modport sink   (input valid, kind, pin_a, pin_b, pin_button, output ready);
endinterface

interface qenc_out_if;
    import qenc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [NET_W-1:0] net_steps;
    logic                    pressed;

    modport source (output valid, net_steps, pressed, input ready);
    modport sink   (input valid, net_steps, pressed, output ready);
endinterface

// ===== design/qenc_decode.sv =====
// Next-state and result logic for one registered encoder item.
// Depends on qenc_pkg.
module qenc_decode (
    input  qenc_pkg::item_t   item,
    input  qenc_pkg::state_t  cur,
    input  qenc_pkg::cfg_t    cfg,
    output qenc_pkg::state_t  nxt,
    output qenc_pkg::result_t result,
    output logic              has_result
);
    import qenc_pkg::*;

    logic [1:0]        ab;
    step_t             step;
    logic              btn;
    logic [DIFF_W-1:0] diff;

    always_comb
    begin
        ab   = {item.pin_a, item.pin_b};
        step = STEP_TABLE[{cur.previous_ab, ab}];
        if (cfg.direction_flip)
        begin
            case (step)
                STEP_POS: step = STEP_NEG;
                STEP_NEG: step = STEP_POS;
                default:  step = STEP_NONE;
            endcase
        end
        btn  = item.pin_button ^ cfg.button_active_low;
        diff = {{(DIFF_W-COUNT_BITS){1'b0}}, cur.cw_count}
             - {{(DIFF_W-COUNT_BITS){1'b0}}, cur.ccw_count};

        result.net_steps = diff[NET_W-1:0];
        result.pressed   = cur.press_pending;
        has_result       = 1'b0;
        nxt              = cur;

        case (item.kind)
            KIND_SAMPLE:
            begin
                if (step == STEP_POS)
                    nxt.cw_count = cur.cw_count + 1'b1;
                if (step == STEP_NEG)
                    nxt.ccw_count = cur.ccw_count + 1'b1;
                nxt.previous_ab  = ab;
                nxt.last_button  = btn;
                nxt.button_known = 1'b1;
                if (cur.button_known && btn && !cur.last_button)
                    nxt.press_pending = 1'b1;
            end
            KIND_READ:
            begin
                has_result        = 1'b1;
                nxt.cw_count      = '0;
                nxt.ccw_count     = '0;
                nxt.press_pending = 1'b0;
            end
            KIND_SEED:
            begin
                nxt.previous_ab = ab;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== design/qenc_out_reg.sv =====
// Result register driving the output channel.
// Depends on qenc_pkg and qenc_out_if.
module qenc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  qenc_pkg::result_t data,
    output logic              free,
    qenc_out_if.source        out_ch
);
    import qenc_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= data;
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.net_steps = data_reg.net_steps;
    assign out_ch.pressed   = data_reg.pressed;

endmodule

// ===== design/quadrature_encoder_events_core.sv =====
// Top level of the quadrature encoder event unit.
// Depends on qenc_pkg, qenc_if, qenc_decode and qenc_out_reg.
//
//   channel  dir  beat                               notes
//   in_ch    in   kind, pin_a, pin_b, pin_button     sample / read / seed
//   out_ch   out  net_steps, pressed                 one beat per read item
//   cfg      in   cfg_we, cfg_index, cfg_wdata        direction_flip, button_active_low
//
// One item per cycle while no read item is stalled; an accepted beat is held in the input register.
// When that beat fires, the state register updates and a read loads the result register, so a read's beat
// is offered on out_ch from the result register.
// A read item waits in the input register only while the output register is full and stalled.
// Reset: previous A/B state idle (3), counts and press flag clear, button_active_low set.
module quadrature_encoder_events_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [qenc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qenc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    qenc_in_if.sink                               in_ch,
    qenc_out_if.source                            out_ch
);
    import qenc_pkg::*;

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result;
    logic    has_result;
    logic    out_free;
    logic    s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_flip    <= 1'b0;
            cfg_reg.button_active_low <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION_FLIP:    cfg_reg.direction_flip    <= cfg_wdata[0];
                CFG_BUTTON_ACTIVE_LOW: cfg_reg.button_active_low <= cfg_wdata[0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s1_fire     = s1_valid_reg && (s1_item_reg.kind != KIND_READ || out_free);
    assign in_ch.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_item_reg.kind       <= in_ch.kind;
            s1_item_reg.pin_a      <= in_ch.pin_a;
            s1_item_reg.pin_b      <= in_ch.pin_b;
            s1_item_reg.pin_button <= in_ch.pin_button;
        end
    end

    qenc_decode u_decode (
        .item       (s1_item_reg),
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .nxt        (state_next),
        .result     (result),
        .has_result (has_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.previous_ab   <= AB_IDLE;
            state_reg.cw_count      <= '0;
            state_reg.ccw_count     <= '0;
            state_reg.last_button   <= 1'b0;
            state_reg.button_known  <= 1'b0;
            state_reg.press_pending <= 1'b0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    qenc_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s1_fire && has_result),
        .data   (result),
        .free   (out_free),
        .out_ch (out_ch)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.kind == KIND_READ) |=>
            (state_reg.cw_count == '0 && state_reg.ccw_count == '0
             && !state_reg.press_pending))
        else $error("counts or press flag not cleared after read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.kind == KIND_SAMPLE) |=>
            !(state_reg.cw_count != $past(state_reg.cw_count)
              && state_reg.ccw_count != $past(state_reg.ccw_count)))
        else $error("both step counts moved on one sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.press_pending) |-> $past(state_reg.button_known))
        else $error("press flagged before button level was primed");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(s1_fire && s1_item_reg.kind == KIND_READ))
        else $error("result beat without a read item");

endmodule

// ===== bench/tb_quadrature_encoder_events_core.sv =====
// Self-checking bench for quadrature_encoder_events_core: step decode, count wrap, button press.
// Drives encoder beats against a local copy of the decoder state and checks every report.
// Depends on qenc_pkg, qenc_if and the design under bench.
module tb_quadrature_encoder_events_core;
    timeunit 1ns;
    timeprecision 1ps;

    import qenc_pkg::*;

    localparam int MAX_SHOWN     = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    qenc_in_if  in_ch ();
    qenc_out_if out_ch ();

    quadrature_encoder_events_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // decoder state as the block should hold it
    logic [1:0]            enc_prev_ab     = AB_IDLE;
    logic [COUNT_BITS-1:0] enc_cw_count    = '0;
    logic [COUNT_BITS-1:0] enc_ccw_count   = '0;
    logic                  enc_last_button = 1'b0;
    logic                  enc_button_seen = 1'b0;
    logic                  enc_press       = 1'b0;
    logic                  enc_flip        = 1'b0;
    logic                  enc_active_low  = 1'b1;

    result_t pending_reports [$];

    int   beats_sent;
    int   reports_seen;
    int   presses_seen;
    int   mismatches;
    bit   sender_gaps;
    bit   sink_stalls;
    logic button_raw;
    bit   spin_cw;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int quad_step(logic [1:0] from_ab, logic [1:0] to_ab);
        case ({from_ab, to_ab})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [1:0] next_ab(logic [1:0] ab, bit cw);
        case (ab)
            2'b00:   return cw ? 2'b01 : 2'b10;
            2'b01:   return cw ? 2'b11 : 2'b00;
            2'b11:   return cw ? 2'b10 : 2'b01;
            default: return cw ? 2'b00 : 2'b11;
        endcase
    endfunction

    task automatic track_encoder(kind_t kind, logic a, logic b, logic raw_button);
        int          step;
        logic        level;
        logic [31:0] diff;
        result_t     report;
        case (kind)
            KIND_SAMPLE:
            begin
                step = quad_step(enc_prev_ab, {a, b});
                if (enc_flip)
                    step = -step;
                if (step > 0)
                    enc_cw_count = enc_cw_count + 1'b1;
                else if (step < 0)
                    enc_ccw_count = enc_ccw_count + 1'b1;
                enc_prev_ab = {a, b};
                level = raw_button ^ enc_active_low;
                if (!enc_button_seen)
                begin
                    enc_last_button = level;
                    enc_button_seen = 1'b1;
                end
                else if (level != enc_last_button)
                begin
                    enc_last_button = level;
                    if (level)
                        enc_press = 1'b1;
                end
            end
            KIND_READ:
            begin
                diff = 32'(enc_cw_count) - 32'(enc_ccw_count);
                report.net_steps = diff[NET_W-1:0];
                report.pressed   = enc_press;
                pending_reports.push_back(report);
                enc_cw_count  = '0;
                enc_ccw_count = '0;
                enc_press     = 1'b0;
            end
            KIND_SEED: enc_prev_ab = {a, b};
            default: ;
        endcase
    endtask

    task automatic send_beat(kind_t kind, logic a, logic b, logic raw_button);
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.pin_a      <= a;
        in_ch.pin_b      <= b;
        in_ch.pin_button <= raw_button;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_encoder(kind, a, b, raw_button);
        beats_sent++;
    endtask

    task automatic send_read();
        send_beat(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic spin(bit cw, int steps);
        logic [1:0] ab;
        repeat (steps)
        begin
            if ($urandom_range(0, 15) == 0)
                button_raw = ~button_raw;
            ab = next_ab(enc_prev_ab, cw);
            send_beat(KIND_SAMPLE, ab[1], ab[0], button_raw);
        end
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic set_config(logic flip, logic active_low);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIRECTION_FLIP;
        cfg_wdata <= flip;
        @(posedge clk);
        cfg_index <= CFG_BUTTON_ACTIVE_LOW;
        cfg_wdata <= active_low;
        @(posedge clk);
        cfg_we         <= 1'b0;
        enc_flip       = flip;
        enc_active_low = active_low;
    endtask

    task automatic test_directed();
        send_read();
        send_beat(KIND_SAMPLE, 1'b1, 1'b1, 1'b1);
        send_beat(KIND_SAMPLE, 1'b1, 1'b0, 1'b1);
        send_beat(KIND_SAMPLE, 1'b0, 1'b0, 1'b0);
        send_beat(KIND_SAMPLE, 1'b0, 1'b1, 1'b0);
        send_beat(KIND_SAMPLE, 1'b1, 1'b1, 1'b1);
        send_read();
        send_read();
        send_beat(KIND_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_beat(KIND_SAMPLE, 1'b0, 1'b0, 1'b1);
        send_beat(KIND_SAMPLE, 1'b1, 1'b0, 1'b1);
        send_beat(KIND_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_beat(KIND_SEED, 1'b1, 1'b1, 1'b0);
        send_beat(KIND_SAMPLE, 1'b1, 1'b1, 1'b1);
        send_beat(kind_t'(2'd3), 1'b0, 1'b0, 1'b0);
        send_beat(KIND_SAMPLE, 1'b1, 1'b1, 1'b1);
        send_read();
        send_beat(KIND_SEED, 1'b0, 1'b0, 1'b1);
        send_beat(KIND_SAMPLE, 1'b1, 1'b0, 1'b0);
        send_beat(kind_t'(2'd3), 1'b1, 1'b1, 1'b1);
        send_read();
    endtask

    task automatic test_count_extremes();
        send_read();
        spin(1'b0, 255);
        send_read();
        spin(1'b1, 257);
        send_read();
    endtask

    task automatic test_random_mix(logic flip, logic active_low, int beats, bit drain_midway);
        int         pick;
        logic [1:0] ab;
        logic [1:0] step_ab;
        set_config(flip, active_low);
        for (int i = 0; i < beats; i++)
        begin
            if (drain_midway && i == beats / 2)
                hold_until_drained();
            if ($urandom_range(0, 11) == 0)
                button_raw = ~button_raw;
            if ($urandom_range(0, 15) == 0)
                spin_cw = ~spin_cw;
            pick    = $urandom_range(0, 99);
            ab      = 2'($urandom_range(0, 3));
            step_ab = next_ab(enc_prev_ab, spin_cw);
            if (pick < 68)
                send_beat(KIND_SAMPLE, step_ab[1], step_ab[0], button_raw);
            else if (pick < 74)
                send_beat(KIND_SAMPLE, enc_prev_ab[1], enc_prev_ab[0], button_raw);
            else if (pick < 80)
                send_beat(KIND_SAMPLE, ab[1], ab[0], button_raw);
            else if (pick < 92)
                send_read();
            else if (pick < 97)
                send_beat(KIND_SEED, ab[1], ab[0], 1'($urandom_range(0, 1)));
            else
                send_beat(kind_t'(2'd3), ab[1], ab[0], 1'($urandom_range(0, 1)));
        end
        send_read();
    endtask

    // sink side: stall in bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_reports
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] unexpected report: net_steps %0d pressed %0b",
                             $realtime, out_ch.net_steps, out_ch.pressed);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want.pressed)
                    presses_seen++;
                if (out_ch.net_steps !== want.net_steps || out_ch.pressed !== want.pressed)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("[%0t] mismatch: net %0d/%0d pressed %0b/%0b (exp/got)",
                                 $realtime, want.net_steps, out_ch.net_steps,
                                 want.pressed, out_ch.pressed);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d reports outstanding", pending_reports.size());
        $display("** quadrature_encoder_events_core: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_DIRECTION_FLIP;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_SAMPLE;
        in_ch.pin_a      <= 1'b0;
        in_ch.pin_b      <= 1'b0;
        in_ch.pin_button <= 1'b0;
        beats_sent   = 0;
        reports_seen = 0;
        presses_seen = 0;
        mismatches   = 0;
        sender_gaps  = 1'b1;
        sink_stalls  = 1'b1;
        button_raw   = 1'b1;
        spin_cw      = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_config(1'b0, 1'b1);
        test_directed();
        test_count_extremes();
        test_random_mix(1'b1, 1'b1, 65, 1'b0);
        test_random_mix(1'b1, 1'b0, 65, 1'b1);
        test_random_mix(1'b0, 1'b0, 65, 1'b0);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_mix(1'b0, 1'b1, 65, 1'b0);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d beats in and %0d reports out (%0d with a press), %0d mismatches",
                 beats_sent, reports_seen, presses_seen, mismatches);
        $display("over four direction/polarity settings, count wrap and full-rate traffic");
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("** quadrature_encoder_events_core: PASSED **");
        else
            $display("** quadrature_encoder_events_core: FAILED **");
        $finish;
    end

endmodule
